FILE: hw/rtl/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

    localparam int CP_W = 21;

    // Lead and continuation byte patterns
    localparam logic [7:0] ASCII_MAX  = 8'h7f;
    localparam logic [7:0] MASK_LEAD2 = 8'he0;
    localparam logic [7:0] PAT_LEAD2  = 8'hc0;
    localparam logic [7:0] MASK_LEAD3 = 8'hf0;
    localparam logic [7:0] PAT_LEAD3  = 8'he0;
    localparam logic [7:0] MASK_LEAD4 = 8'hf8;
    localparam logic [7:0] PAT_LEAD4  = 8'hf0;
    localparam logic [7:0] MASK_CONT  = 8'hc0;
    localparam logic [7:0] PAT_CONT   = 8'h80;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10ffff;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00d800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00dfff;
    localparam logic [CP_W-1:0] CP_CTRL_END = 21'h000020;
    localparam logic [CP_W-1:0] CP_DEL      = 21'h00007f;

    // Continuation counts
    localparam logic [1:0] CONT_NONE = 2'd0;
    localparam logic [1:0] CONT_ONE  = 2'd1;
    localparam logic [1:0] CONT_TWO  = 2'd2;
    localparam logic [1:0] CONT_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       last;
    } u8v_item_t;

    typedef struct packed {
        logic [1:0]      pending_continuations;
        logic [1:0]      sequence_length;
        logic [CP_W-1:0] code_accumulator;
        logic            failed_flag;
        logic            seen_any_byte;
    } u8v_state_t;

endpackage

FILE: hw/rtl/u8v_in_if.sv
// ----------------------------------------------------------------------------
// u8v_in_if
// Byte request channel: one string byte or end marker per request.
// ----------------------------------------------------------------------------
interface u8v_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       last;

    modport source (output valid, output data_byte, output carries_byte,
                    output last, input ready);
    modport sink   (input valid, input data_byte, input carries_byte,
                    input last, output ready);

endinterface

FILE: hw/rtl/u8v_out_if.sv
// ----------------------------------------------------------------------------
// u8v_out_if
// Verdict request channel: one verdict per string.
// ----------------------------------------------------------------------------
interface u8v_out_if;

    logic valid;
    logic ready;
    logic is_valid;

    modport source (output valid, output is_valid, input ready);
    modport sink   (input valid, input is_valid, output ready);

endinterface

FILE: hw/rtl/u8v_in_reg.sv
// ----------------------------------------------------------------------------
// u8v_in_reg
// Input register: captures one request and holds it until consumed.
// ----------------------------------------------------------------------------
module u8v_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    u8v_in_if.sink             byte_ch,
    input  logic               take,
    output logic               item_valid,
    output u8v_pkg::u8v_item_t item
);
    import u8v_pkg::*;

    logic      valid_reg;
    u8v_item_t item_reg;

    // Accept whenever the register is empty or drains this cycle
    assign byte_ch.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            item_reg.data_byte    <= byte_ch.data_byte;
            item_reg.carries_byte <= byte_ch.carries_byte;
            item_reg.last         <= byte_ch.last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/u8v_step.sv
// ----------------------------------------------------------------------------
// u8v_step
// Per-byte decode: next decoder state and the verdict for a closing item.
// ----------------------------------------------------------------------------
module u8v_step (
    input  u8v_pkg::u8v_state_t state,
    input  u8v_pkg::u8v_item_t  item,
    output u8v_pkg::u8v_state_t state_next,
    output logic                verdict
);
    import u8v_pkg::*;

    function automatic logic cp_bad(input logic [CP_W-1:0] cp, input logic [1:0] conts);
        logic bad;
        bad = 1'b0;
        if (conts == CONT_ONE && cp < CP_MIN_2B) bad = 1'b1;
        if (conts == CONT_TWO && cp < CP_MIN_3B) bad = 1'b1;
        if (conts == CONT_THREE && cp < CP_MIN_4B) bad = 1'b1;
        if (cp > CP_MAX) bad = 1'b1;
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) bad = 1'b1;
        if (cp < CP_CTRL_END || cp == CP_DEL) bad = 1'b1;
        return bad;
    endfunction

    u8v_state_t      upd;
    logic [7:0]      b;
    logic [CP_W-1:0] acc_shift;
    logic [1:0]      pend_dec;

    assign b         = item.data_byte;
    assign acc_shift = {state.code_accumulator[CP_W-7:0], b[5:0]};
    assign pend_dec  = state.pending_continuations - 2'd1;

    always_comb
    begin
        upd = state;
        if (item.carries_byte)
        begin
            upd.seen_any_byte = 1'b1;
            if (!state.failed_flag)
            begin
                if (state.pending_continuations == CONT_NONE)
                begin
                    if (b <= ASCII_MAX)
                    begin
                        if (cp_bad({13'd0, b}, CONT_NONE))
                        begin
                            upd.failed_flag = 1'b1;
                        end
                    end
                    else if ((b & MASK_LEAD2) == PAT_LEAD2)
                    begin
                        upd.pending_continuations = CONT_ONE;
                        upd.sequence_length       = CONT_ONE;
                        upd.code_accumulator      = {16'd0, b[4:0]};
                    end
                    else if ((b & MASK_LEAD3) == PAT_LEAD3)
                    begin
                        upd.pending_continuations = CONT_TWO;
                        upd.sequence_length       = CONT_TWO;
                        upd.code_accumulator      = {17'd0, b[3:0]};
                    end
                    else if ((b & MASK_LEAD4) == PAT_LEAD4)
                    begin
                        upd.pending_continuations = CONT_THREE;
                        upd.sequence_length       = CONT_THREE;
                        upd.code_accumulator      = {18'd0, b[2:0]};
                    end
                    else
                    begin
                        upd.failed_flag = 1'b1;
                    end
                end
                else if ((b & MASK_CONT) != PAT_CONT)
                begin
                    upd.failed_flag           = 1'b1;
                    upd.pending_continuations = CONT_NONE;
                end
                else
                begin
                    upd.code_accumulator      = acc_shift;
                    upd.pending_continuations = pend_dec;
                    if (pend_dec == CONT_NONE && cp_bad(acc_shift, state.sequence_length))
                    begin
                        upd.failed_flag = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        verdict = !upd.failed_flag && upd.pending_continuations == CONT_NONE
                  && upd.seen_any_byte;
        state_next = item.last ? '0 : upd;
    end

endmodule

FILE: hw/rtl/utf8_stream_validator_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit
// Restricted UTF-8 validator: one byte or end marker per request, one verdict per string.
// ----------------------------------------------------------------------------
//
//  channel     | role   | payload                           | requests
//  ------------+--------+-----------------------------------+-----------------
//  byte_ch     | sink   | data_byte, carries_byte, last     | one per byte or end
//  verdict_ch  | source | is_valid                          | one per string
//
//  One request per cycle sustained unless a closing request is held back.
//  A request is decoded while it sits in the input register; the decoder
//  state and, for a closing request, the verdict register load when the
//  request is consumed; the verdict is then offered on verdict_ch.
//  Reset clears the decoder state and both valid flags.
//  A closing request waits in the input register only while an earlier
//  verdict is still held on verdict_ch; other requests never wait.
//
module utf8_stream_validator_unit (
    input  logic      clk,
    input  logic      rst_n,
    u8v_in_if.sink    byte_ch,
    u8v_out_if.source verdict_ch
);
    import u8v_pkg::*;

    logic       item_valid;
    u8v_item_t  item;
    logic       fire;
    u8v_state_t state_reg;
    u8v_state_t state_next;
    logic       verdict;
    logic       out_valid_reg;
    logic       out_data_reg;

    // Hold a closing request back only while the verdict slot stays full
    assign fire = item_valid && (!item.last || !out_valid_reg || verdict_ch.ready);

    u8v_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    u8v_step u_step (
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .verdict    (verdict)
    );

    // Advance the decoder state once per consumed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Verdict register: load on a closing request, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && item.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item.last)
        begin
            out_data_reg <= verdict;
        end
    end

    assign verdict_ch.valid    = out_valid_reg;
    assign verdict_ch.is_valid = out_data_reg;

    // A closing request returns the decoder to its reset state
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last |=> state_reg == '0)
        else $error("decoder state not cleared after closing request");

    // A failure never leaves continuations outstanding
    a_fail_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.failed_flag |-> state_reg.pending_continuations == CONT_NONE)
        else $error("pending continuations while failed");

    // Outstanding continuations never exceed the sequence length
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending_continuations <= state_reg.sequence_length)
        else $error("pending continuations exceed sequence length");

    // A new verdict appears only after a closing request was consumed
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire && item.last))
        else $error("verdict without closing request");

endmodule
